// ===== design/bit_field_stream_buffer_assert.svh =====
// assertion macros for the bit field stream buffer
`ifndef BIT_FIELD_STREAM_BUFFER_ASSERT_SVH
`define BIT_FIELD_STREAM_BUFFER_ASSERT_SVH

`ifndef ASSERT_OFF
`define BFSB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BFSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFSB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define BFSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/bfsb_pkg.sv =====
package bfsb_pkg;

    localparam int unsigned BUFFER_WORDS_DEF = 1024;
    localparam int unsigned WORD_W           = 32;
    localparam logic [15:0] SIZE_RESET       = 16'h8000;
    localparam logic [15:0] CUR_MAX          = 16'hFFFF;
    localparam int unsigned APB_AW           = 3;

    // register select is paddr[2]
    localparam logic REG_SIZE_BITS = 1'b0;

    localparam logic [2:0] OP_WR_U = 3'd0;
    localparam logic [2:0] OP_WR_S = 3'd1;
    localparam logic [2:0] OP_RD_U = 3'd2;
    localparam logic [2:0] OP_RD_S = 3'd3;
    localparam logic [2:0] OP_SEEK = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value;
        logic [5:0]  width;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        overflowed;
        logic [15:0] cursor;
    } t_out_item;

    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [15:0] pos;
        logic [5:0]  len;
        logic [5:0]  low_len;
        logic [4:0]  ext_len;
        logic        sign_ok;
        logic [31:0] data;
        logic [15:0] cursor;
        logic        ovf;
    } t_plan;

    typedef struct packed {
        logic        we;
        logic [31:0] data;
    } t_bank_wr;

    function automatic logic [31:0] f_mask(input logic [5:0] n);
        logic [31:0] m;
        m = (n >= 6'd32) ? 32'hFFFF_FFFF : ((32'h1 << n[4:0]) - 32'h1);
        return m;
    endfunction

endpackage

// ===== design/bit_field_stream_buffer.sv =====
// port      dir   handshake                       payload
// in        in    i_in_valid / o_in_ready         t_in_item (operation, value, width)
// out       out   o_out_valid / i_out_ready       t_out_item (read_data, overflowed, cursor)
// apb       in    psel, penable, pwrite / pready  size_bits at byte address 0
//
// per transaction: in S_IDLE the accept plans the access and reads the word pair
// from the even and odd banks; S_MERGE then merges, writes back and loads the result
// the single-port banks set the pace: read then write per transaction
// synchronous active-low reset clears cursor and flag and sets size_bits to 32768;
// the word store is not cleared
// a result waits in the output register while the next item is accepted; the merge
// step holds until that register is free
`include "bit_field_stream_buffer_assert.svh"

module bit_field_stream_buffer import bfsb_pkg::*; #(
    parameter int unsigned BUFFER_WORDS = BUFFER_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int unsigned EVEN_D   = (BUFFER_WORDS + 1) / 2;
    localparam int unsigned ODD_D    = BUFFER_WORDS / 2;
    localparam int unsigned EVEN_AW  = (EVEN_D > 1) ? $clog2(EVEN_D) : 1;
    localparam int unsigned ODD_AW   = (ODD_D > 1) ? $clog2(ODD_D) : 1;
    localparam int unsigned CAP_BITS = BUFFER_WORDS * WORD_W;
    localparam logic [15:0] CAP_LIM  = (CAP_BITS > 32'(CUR_MAX)) ? CUR_MAX : 16'(CAP_BITS);

    typedef enum logic {
        S_IDLE,
        S_MERGE
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_size, n_size;
    logic [15:0] r_cursor, n_cursor;
    logic        r_ovf, n_ovf;
    logic        r_out_valid, n_out_valid;
    t_plan       r_plan, n_plan;
    t_out_item   r_out, n_out;

    logic [15:0] lim;
    logic        in_fire;
    logic        out_load;
    logic        cfg_wr;
    t_plan       plan;
    t_bank_wr    even_wr;
    t_bank_wr    odd_wr;
    logic [31:0] even_rdata;
    logic [31:0] odd_rdata;
    logic [31:0] read_data;
    logic [15:0] addr_pos;
    logic [10:0] even_addr;
    logic [10:0] odd_addr;
    logic        even_we;
    logic        odd_we;

    assign lim      = (r_size < CAP_LIM) ? r_size : CAP_LIM;
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_MERGE) && (!r_out_valid || i_out_ready);
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_SIZE_BITS);

    bfsb_plan u_plan (
        .i_item   (i_in_data),
        .i_cursor (r_cursor),
        .i_ovf    (r_ovf),
        .i_lim    (lim),
        .o_plan   (plan)
    );

    // read at the cursor on accept, write back at the planned position
    assign addr_pos  = (r_state == S_IDLE) ? r_cursor : r_plan.pos;
    assign odd_addr  = {1'b0, addr_pos[15:6]};
    assign even_addr = {1'b0, addr_pos[15:6]} + {10'b0, addr_pos[5]};
    assign even_we   = out_load && even_wr.we;
    assign odd_we    = out_load && odd_wr.we;

    bfsb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (EVEN_D)
    ) u_even_ram (
        .i_clk   (i_clk),
        .i_en    (in_fire || even_we),
        .i_we    (even_we),
        .i_addr  (EVEN_AW'(even_addr)),
        .i_wdata (even_wr.data),
        .o_rdata (even_rdata)
    );

    bfsb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ODD_D)
    ) u_odd_ram (
        .i_clk   (i_clk),
        .i_en    (in_fire || odd_we),
        .i_we    (odd_we),
        .i_addr  (ODD_AW'(odd_addr)),
        .i_wdata (odd_wr.data),
        .o_rdata (odd_rdata)
    );

    bfsb_merge u_merge (
        .i_plan       (r_plan),
        .i_even_rdata (even_rdata),
        .i_odd_rdata  (odd_rdata),
        .o_even_wr    (even_wr),
        .o_odd_wr     (odd_wr),
        .o_read_data  (read_data)
    );

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_cursor    = r_cursor;
        n_ovf       = r_ovf;
        n_plan      = r_plan;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_plan   = plan;
                    n_cursor = plan.cursor;
                    n_ovf    = plan.ovf;
                    n_state  = S_MERGE;
                end
            end
            S_MERGE: begin
                if (out_load) begin
                    n_out.read_data  = read_data;
                    n_out.overflowed = r_ovf;
                    n_out.cursor     = r_cursor;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_wr) begin
            n_size = pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= SIZE_RESET;
            r_cursor    <= 16'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_cursor    <= n_cursor;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_plan <= n_plan;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign prdata      = (paddr[2] == REG_SIZE_BITS) ? {16'b0, r_size} : 32'b0;
    assign pready      = 1'b1;

    `BFSB_ASSERT_IMPLIES(a_write_in_merge, i_clk, i_rst_n, even_we || odd_we, r_state == S_MERGE, "bank write outside merge")
    `BFSB_ASSERT_NEXT(a_accept_to_merge, i_clk, i_rst_n, in_fire, r_state == S_MERGE, "accepted transaction did not enter merge")
    `BFSB_ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n, r_ovf && !(in_fire && (i_in_data.operation == OP_SEEK)), r_ovf, "overflow flag cleared without seek")
    `BFSB_ASSERT_NEXT(a_cursor_hold, i_clk, i_rst_n, !in_fire, $stable(r_cursor), "cursor moved without a transaction")

endmodule

// ===== design/bfsb_ram.sv =====
module bfsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bfsb_plan.sv =====
module bfsb_plan import bfsb_pkg::*; (
    input  t_in_item    i_item,
    input  logic [15:0] i_cursor,
    input  logic        i_ovf,
    input  logic [15:0] i_lim,
    output t_plan       o_plan
);

    logic [5:0]  w;
    logic [4:0]  u;
    logic [5:0]  fw;
    logic [16:0] end1;
    logic        fit1;
    logic        is_signed;
    logic        is_rd;
    logic        is_wr;
    logic        short_rd;
    logic        ovf_n;
    logic [31:0] pattern;

    always_comb begin
        w         = (i_item.width > 6'd32) ? 6'd32 : i_item.width;
        u         = (w == 6'd0) ? 5'd0 : 5'(w - 6'd1);
        is_signed = (i_item.operation == OP_WR_S) || (i_item.operation == OP_RD_S);
        is_rd     = (i_item.operation == OP_RD_U) || (i_item.operation == OP_RD_S);
        is_wr     = (i_item.operation == OP_WR_U) || (i_item.operation == OP_WR_S);
        fw        = is_signed ? {1'b0, u} : w;
        end1      = {1'b0, i_cursor} + {11'b0, fw};
        fit1      = end1 <= {1'b0, i_lim};
        // byte read with fewer than eight bits left: no overflow, unless a signed read has no bit left
        short_rd  = is_rd && (fw == 6'd8) && (i_cursor <= i_lim) && !fit1;
        ovf_n     = i_ovf;

        // signed fields carry the sign bit right above the low part
        pattern = i_item.value & f_mask(fw);
        if (is_signed) begin
            pattern = pattern | ({31'b0, i_item.value[31]} << fw[4:0]);
        end

        o_plan         = '0;
        o_plan.rd      = is_rd;
        o_plan.pos     = i_cursor;
        o_plan.low_len = fw;
        o_plan.ext_len = u;
        o_plan.cursor  = i_cursor;
        o_plan.ovf     = i_ovf;

        if (i_item.operation == OP_SEEK) begin
            o_plan.cursor = (i_item.value < {16'b0, i_lim}) ? i_item.value[15:0] : i_lim;
            o_plan.ovf    = 1'b0;
        end else if (is_rd || is_wr) begin
            priority if (short_rd) begin
                if (is_signed) begin
                    // sign bit read at the cursor itself
                    ovf_n          = i_ovf || (i_cursor >= i_lim);
                    o_plan.ovf     = ovf_n;
                    o_plan.sign_ok = !ovf_n;
                    o_plan.low_len = 6'd0;
                    o_plan.len     = {5'b0, !ovf_n};
                    o_plan.cursor  = i_cursor + {15'b0, !ovf_n};
                end
            end else if (!fit1) begin
                o_plan.ovf    = 1'b1;
                o_plan.cursor = i_lim;
            end else begin
                o_plan.wr = is_wr;
                if (is_signed) begin
                    ovf_n          = i_ovf || (end1 >= {1'b0, i_lim});
                    o_plan.ovf     = ovf_n;
                    o_plan.sign_ok = !ovf_n;
                    o_plan.len     = fw + {5'b0, !ovf_n};
                    o_plan.cursor  = end1[15:0] + {15'b0, !ovf_n};
                end else begin
                    o_plan.len    = fw;
                    o_plan.cursor = end1[15:0];
                end
            end
        end

        o_plan.data = pattern & f_mask(o_plan.len);
    end

endmodule

// ===== design/bfsb_merge.sv =====
module bfsb_merge import bfsb_pkg::*; (
    input  t_plan       i_plan,
    input  logic [31:0] i_even_rdata,
    input  logic [31:0] i_odd_rdata,
    output t_bank_wr    o_even_wr,
    output t_bank_wr    o_odd_wr,
    output logic [31:0] o_read_data
);

    logic        odd;
    logic [4:0]  off;
    logic [31:0] lo_word;
    logic [31:0] hi_word;
    logic [63:0] raw64;
    logic [63:0] m64;
    logic [63:0] d64;
    logic [63:0] new64;
    logic [31:0] field;
    logic [31:0] rd_base;
    logic        sign_bit;
    logic        lo_we;
    logic        hi_we;

    always_comb begin
        // word idx sits in bank idx[0]; its neighbor in the other bank
        odd     = i_plan.pos[5];
        off     = i_plan.pos[4:0];
        lo_word = odd ? i_odd_rdata : i_even_rdata;
        hi_word = odd ? i_even_rdata : i_odd_rdata;
        raw64   = {hi_word, lo_word};

        m64   = {32'b0, f_mask(i_plan.len)} << off;
        d64   = {32'b0, i_plan.data} << off;
        new64 = (raw64 & ~m64) | d64;
        lo_we = i_plan.wr && (m64[31:0] != 32'b0);
        hi_we = i_plan.wr && (m64[63:32] != 32'b0);

        o_even_wr.we   = odd ? hi_we : lo_we;
        o_even_wr.data = odd ? new64[63:32] : new64[31:0];
        o_odd_wr.we    = odd ? lo_we : hi_we;
        o_odd_wr.data  = odd ? new64[31:0] : new64[63:32];

        field    = 32'(raw64 >> off);
        rd_base  = field & f_mask(i_plan.low_len);
        sign_bit = field[i_plan.low_len[4:0]];

        o_read_data = 32'b0;
        if (i_plan.rd && (i_plan.len != 6'd0)) begin
            o_read_data = rd_base;
            if (i_plan.sign_ok && sign_bit) begin
                o_read_data = rd_base | ~f_mask({1'b0, i_plan.ext_len});
            end
        end
    end

endmodule
